[rtl/core/pfba_pkg.sv]
package pfba_pkg;

  // Field widths of the item and result ports
  localparam int ACT_W    = 3;
  localparam int FRAME_W  = 12;
  localparam int LIM_W    = 13;
  localparam int STATUS_W = 2;

  // Bitmap word geometry
  localparam int WORD_W  = 32;
  localparam int WORD_SH = 5;

  localparam logic [LIM_W-1:0] LIMIT_RST = 13'd4096;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_ALLOC = 3'd0;
  localparam logic [ACT_W-1:0] ACT_FREE  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_MARK  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_RANGE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_QUERY = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFREE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LIMIT  = 2'd2;

  // Bitmap write data select
  typedef enum logic [1:0] {
    W_ZERO,
    W_SET,
    W_CLR,
    W_RANGE
  } wsel_t;

  // Result register update
  typedef enum logic [2:0] {
    RES_NONE,
    RES_OK,
    RES_LIMIT,
    RES_NOFREE,
    RES_QUERY,
    RES_ALLOC
  } res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic  load;
    logic  refill_start;
    logic  row_start;
    logic  row_inc;
    logic  bm_rd;
    logic  bm_wr;
    logic  addr_tgt;
    wsel_t wsel;
    logic  pend_load;
    logic  cache_wr;
    logic  refill_done;
    logic  cache_rd;
    logic  take;
    logic  cache_drop;
    res_t  res;
    logic  post;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             frame_bad;
    logic             range_bad;
    logic             range_empty;
    logic             cache_empty;
    logic             scan_done;
    logic             pend_any;
    logic             fill_last;
    logic             range_last;
    logic             clear_last;
    logic             slot_free;
  } stat_t;

  // Mask of the n lowest bits of a word
  function automatic logic [WORD_W-1:0] low_mask(input logic [WORD_SH-1:0] n);
    low_mask = (WORD_W'(1) << n) - WORD_W'(1);
  endfunction

endpackage

[rtl/core/pfba_ctrl.sv]
module pfba_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  pfba_pkg::stat_t stat,
  output pfba_pkg::cmd_t  cmd
);
  import pfba_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SINGLE,
    S_RNG_RD,
    S_RNG_WR,
    S_REF_RD,
    S_REF_LD,
    S_REF_PICK,
    S_ALLOC_CHK,
    S_ALLOC_TAKE,
    S_ALLOC_RD,
    S_ALLOC_WR,
    S_POST
  } state_t;

  state_t state_r, state_nxt;

  // Hold state; the clearing pass runs first after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  // Sequence commands and next state
  always_comb begin
    cmd       = '0;
    cmd.wsel  = W_ZERO;
    cmd.res   = RES_NONE;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.bm_wr   = 1'b1;
        cmd.wsel    = W_ZERO;
        cmd.row_inc = 1'b1;
        if (stat.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.act) inside
          ACT_ALLOC: begin
            if (stat.cache_empty) begin
              cmd.refill_start = 1'b1;
              state_nxt        = S_REF_RD;
            end else begin
              cmd.cache_rd = 1'b1;
              state_nxt    = S_ALLOC_TAKE;
            end
          end
          ACT_FREE, ACT_MARK, ACT_QUERY: begin
            if (stat.frame_bad) begin
              cmd.res   = RES_LIMIT;
              state_nxt = S_POST;
            end else begin
              cmd.bm_rd    = 1'b1;
              cmd.addr_tgt = 1'b1;
              state_nxt    = S_SINGLE;
            end
          end
          ACT_RANGE: begin
            if (stat.range_bad) begin
              cmd.res   = RES_LIMIT;
              state_nxt = S_POST;
            end else if (stat.range_empty) begin
              cmd.cache_drop = 1'b1;
              cmd.res        = RES_OK;
              state_nxt      = S_POST;
            end else begin
              cmd.row_start = 1'b1;
              state_nxt     = S_RNG_RD;
            end
          end
          default: begin
            cmd.res   = RES_OK;
            state_nxt = S_POST;
          end
        endcase
      end
      S_SINGLE: begin
        cmd.addr_tgt = 1'b1;
        cmd.res      = RES_OK;
        unique case (stat.act)
          ACT_FREE: begin
            cmd.bm_wr = 1'b1;
            cmd.wsel  = W_CLR;
          end
          ACT_MARK: begin
            cmd.bm_wr      = 1'b1;
            cmd.wsel       = W_SET;
            cmd.cache_drop = 1'b1;
          end
          default: begin
            cmd.res = RES_QUERY;
          end
        endcase
        state_nxt = S_POST;
      end
      S_RNG_RD: begin
        cmd.bm_rd = 1'b1;
        state_nxt = S_RNG_WR;
      end
      S_RNG_WR: begin
        cmd.bm_wr   = 1'b1;
        cmd.wsel    = W_RANGE;
        cmd.row_inc = 1'b1;
        if (stat.range_last) begin
          cmd.cache_drop = 1'b1;
          cmd.res        = RES_OK;
          state_nxt      = S_POST;
        end else begin
          state_nxt = S_RNG_RD;
        end
      end
      S_REF_RD: begin
        if (stat.scan_done) begin
          cmd.refill_done = 1'b1;
          state_nxt       = S_ALLOC_CHK;
        end else begin
          cmd.bm_rd = 1'b1;
          state_nxt = S_REF_LD;
        end
      end
      S_REF_LD: begin
        cmd.pend_load = 1'b1;
        state_nxt     = S_REF_PICK;
      end
      S_REF_PICK: begin
        if (stat.pend_any) begin
          cmd.cache_wr = 1'b1;
          if (stat.fill_last) begin
            cmd.refill_done = 1'b1;
            state_nxt       = S_ALLOC_CHK;
          end
        end else begin
          cmd.row_inc = 1'b1;
          state_nxt   = S_REF_RD;
        end
      end
      S_ALLOC_CHK: begin
        if (stat.cache_empty) begin
          cmd.cache_drop = 1'b1;
          cmd.res        = RES_NOFREE;
          state_nxt      = S_POST;
        end else begin
          cmd.cache_rd = 1'b1;
          state_nxt    = S_ALLOC_TAKE;
        end
      end
      S_ALLOC_TAKE: begin
        cmd.take  = 1'b1;
        state_nxt = S_ALLOC_RD;
      end
      S_ALLOC_RD: begin
        cmd.bm_rd    = 1'b1;
        cmd.addr_tgt = 1'b1;
        state_nxt    = S_ALLOC_WR;
      end
      S_ALLOC_WR: begin
        cmd.bm_wr    = 1'b1;
        cmd.addr_tgt = 1'b1;
        cmd.wsel     = W_SET;
        cmd.res      = RES_ALLOC;
        state_nxt    = S_POST;
      end
      S_POST: begin
        if (stat.slot_free) begin
          cmd.post  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/pfba_dp.sv]
module pfba_dp #(
  parameter int MAX_FRAMES  = 4096,
  parameter int CACHE_DEPTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [pfba_pkg::ACT_W-1:0]        in_action,
  input  logic [pfba_pkg::FRAME_W-1:0]      in_frame_number,
  input  logic [pfba_pkg::LIM_W-1:0]        in_range_end,
  input  logic                              cfg_wr_en,
  input  logic [pfba_pkg::LIM_W-1:0]        cfg_frame_limit,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pfba_pkg::FRAME_W-1:0]      out_alloc_frame_number,
  output logic [pfba_pkg::STATUS_W-1:0]     out_status,
  output logic                              out_is_free,
  input  pfba_pkg::cmd_t                    cmd,
  output pfba_pkg::stat_t                   stat
);
  import pfba_pkg::*;

  // Frames reachable through a 13-bit limit, and the bitmap rows that hold them
  localparam int FW    = (MAX_FRAMES < (1 << LIM_W)) ? $clog2(MAX_FRAMES) : LIM_W;
  localparam int RW    = FW - WORD_SH;
  localparam int ROWS  = 1 << RW;
  localparam int CMP_W = LIM_W + 2;
  localparam int CW    = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int NW    = $clog2(CACHE_DEPTH + 1);
  localparam logic [NW-1:0] DEPTH_N = NW'(CACHE_DEPTH);
  localparam logic           CLAMP   = (MAX_FRAMES < (1 << LIM_W));

  logic [WORD_W-1:0]   bitmap_mem [ROWS];
  logic [FW-1:0]       cache_mem  [CACHE_DEPTH];

  logic [LIM_W-1:0]    lim_r;
  logic [ACT_W-1:0]    act_r;
  logic [FRAME_W-1:0]  frame_r;
  logic [LIM_W-1:0]    rend_r;
  logic [FW-1:0]       tgt_r;
  logic [RW:0]         row_r;
  logic [WORD_W-1:0]   rdata_r;
  logic [WORD_W-1:0]   pend_r;
  logic [FW-1:0]       cache_rdata_r;
  logic [NW-1:0]       fill_r;
  logic [NW-1:0]       next_r;
  logic [NW-1:0]       filled_r;
  logic [FRAME_W-1:0]  res_frame_r;
  logic [STATUS_W-1:0] res_status_r;
  logic                res_free_r;
  logic                out_valid_r;
  logic [FRAME_W-1:0]  out_frame_r;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_free_r;

  logic [LIM_W-1:0]    eff_lim;
  logic [CMP_W-1:0]    lim_x;
  logic [CMP_W-1:0]    rend_x;
  logic [CMP_W-1:0]    base_x;
  logic [CMP_W-1:0]    base_end_x;
  logic [RW-1:0]       bm_addr;
  logic [WORD_W-1:0]   bit_onehot;
  logic [WORD_W-1:0]   rng_mask;
  logic [WORD_W-1:0]   lim_mask;
  logic [WORD_W-1:0]   bm_wdata;
  logic [WORD_W-1:0]   pend_low;
  logic [WORD_SH-1:0]  pend_idx;
  logic                start_row;

  // Clamp the limit to the frames the bitmap holds
  assign eff_lim = (CLAMP && (lim_r > LIM_W'(MAX_FRAMES))) ? LIM_W'(MAX_FRAMES) : lim_r;

  assign lim_x      = CMP_W'(eff_lim);
  assign rend_x     = CMP_W'(rend_r);
  assign base_x     = CMP_W'({row_r, {WORD_SH{1'b0}}});
  assign base_end_x = base_x + CMP_W'(WORD_W);

  assign bm_addr    = cmd.addr_tgt ? tgt_r[FW-1:WORD_SH] : row_r[RW-1:0];
  assign bit_onehot = WORD_W'(1) << tgt_r[WORD_SH-1:0];
  assign start_row  = (row_r[RW-1:0] == tgt_r[FW-1:WORD_SH]);

  // Build the range mask for the current row
  always_comb begin
    rng_mask = '1;
    if (start_row) rng_mask = ~low_mask(tgt_r[WORD_SH-1:0]);
    if (base_end_x > rend_x) rng_mask = rng_mask & low_mask(rend_r[WORD_SH-1:0]);
  end

  // Keep only frames below the limit, and never frame zero
  always_comb begin
    lim_mask = '1;
    if (base_end_x > lim_x) lim_mask = low_mask(eff_lim[WORD_SH-1:0]);
    if (row_r == '0) lim_mask[0] = 1'b0;
  end

  // Select bitmap write data
  always_comb begin
    case (cmd.wsel)
      W_SET:   bm_wdata = rdata_r | bit_onehot;
      W_CLR:   bm_wdata = rdata_r & ~bit_onehot;
      W_RANGE: bm_wdata = rdata_r | rng_mask;
      default: bm_wdata = '0;
    endcase
  end

  // Isolate and encode the lowest free candidate
  always_comb begin
    pend_low = pend_r & (~pend_r + WORD_W'(1));
    pend_idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (pend_low[i]) pend_idx = pend_idx | WORD_SH'(i);
    end
  end

  // Bitmap memory
  always_ff @(posedge clk) begin
    if (cmd.bm_wr) bitmap_mem[bm_addr] <= bm_wdata;
    if (cmd.bm_rd) rdata_r <= bitmap_mem[bm_addr];
  end

  // Free frame cache memory
  always_ff @(posedge clk) begin
    if (cmd.cache_wr) begin
      cache_mem[fill_r[CW-1:0]] <= FW'({row_r[RW-1:0], pend_idx});
    end
    if (cmd.cache_rd) cache_rdata_r <= cache_mem[next_r[CW-1:0]];
  end

  // Latch the item and track the working frame
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r   <= in_action;
      frame_r <= in_frame_number;
      rend_r  <= in_range_end;
      tgt_r   <= FW'({{LIM_W{1'b0}}, in_frame_number});
    end else if (cmd.take) begin
      tgt_r <= cache_rdata_r;
    end
    if (cmd.pend_load) begin
      pend_r <= ~rdata_r & lim_mask;
    end else if (cmd.cache_wr) begin
      pend_r <= pend_r & ~pend_low;
    end
  end

  // Advance the row pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else if (cmd.refill_start) begin
      row_r <= '0;
    end else if (cmd.row_start) begin
      row_r <= {1'b0, tgt_r[FW-1:WORD_SH]};
    end else if (cmd.row_inc) begin
      row_r <= row_r + 1'b1;
    end
  end

  // Hold the limit and the cache pointers; a limit write drops the cache
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r    <= LIMIT_RST;
      fill_r   <= '0;
      next_r   <= DEPTH_N;
      filled_r <= DEPTH_N;
    end else begin
      if (cfg_wr_en) lim_r <= cfg_frame_limit;
      if (cmd.refill_start) begin
        fill_r <= '0;
      end else if (cmd.cache_wr) begin
        fill_r <= fill_r + 1'b1;
      end
      if (cfg_wr_en || cmd.cache_drop) begin
        next_r   <= DEPTH_N;
        filled_r <= DEPTH_N;
      end else if (cmd.refill_done) begin
        next_r   <= '0;
        filled_r <= fill_r + NW'(cmd.cache_wr);
      end else if (cmd.take) begin
        next_r <= next_r + 1'b1;
      end
    end
  end

  // Form the result of the transaction
  always_ff @(posedge clk) begin
    case (cmd.res)
      RES_OK: begin
        res_frame_r  <= '0;
        res_status_r <= ST_OK;
        res_free_r   <= 1'b0;
      end
      RES_LIMIT: begin
        res_frame_r  <= '0;
        res_status_r <= ST_LIMIT;
        res_free_r   <= 1'b0;
      end
      RES_NOFREE: begin
        res_frame_r  <= '0;
        res_status_r <= ST_NOFREE;
        res_free_r   <= 1'b0;
      end
      RES_QUERY: begin
        res_frame_r  <= '0;
        res_status_r <= ST_OK;
        res_free_r   <= ~rdata_r[tgt_r[WORD_SH-1:0]];
      end
      RES_ALLOC: begin
        res_frame_r  <= FRAME_W'({{FRAME_W{1'b0}}, tgt_r});
        res_status_r <= ST_OK;
        res_free_r   <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.post) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.post) begin
      out_frame_r  <= res_frame_r;
      out_status_r <= res_status_r;
      out_free_r   <= res_free_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_alloc_frame_number = out_frame_r;
  assign out_status             = out_status_r;
  assign out_is_free            = out_free_r;

  // Report status to the controller
  always_comb begin
    stat.act         = act_r;
    stat.frame_bad   = ({1'b0, frame_r} >= eff_lim);
    stat.range_bad   = (rend_r > eff_lim) || ({1'b0, frame_r} > rend_r);
    stat.range_empty = ({1'b0, frame_r} == rend_r);
    stat.cache_empty = (next_r >= filled_r);
    stat.scan_done   = (base_x >= lim_x);
    stat.pend_any    = (pend_r != '0);
    stat.fill_last   = (fill_r == NW'(CACHE_DEPTH - 1));
    stat.range_last  = (base_end_x >= rend_x);
    stat.clear_last  = (&row_r[RW-1:0]);
    stat.slot_free   = !out_valid_r || !out_stall;
  end

endmodule

[rtl/core/page_frame_bitmap_allocator_core.sv]
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_stall   | action, frame_number, range_end
// out_    | output    | out_valid / out_stall | alloc_frame_number, status, is_free
// cfg_    | input     | cfg_wr_en             | frame_limit
//
// One transaction at a time. Query, free and mark read one bitmap word, and free and
// mark write it back; alloc takes a frame from the cache. A range mark reads and writes
// back each bitmap word touched. A refill scans the bitmap one 32-frame word at a time
// and caches the free frames. After reset a clearing pass writes every bitmap word once
// (128 words by default, 2**FW/32 in general); in_stall stays high until it ends.
// A result waiting under out_stall does not block the next accept.
module page_frame_bitmap_allocator_core #(
  parameter int MAX_FRAMES  = 4096,
  parameter int CACHE_DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pfba_pkg::ACT_W-1:0]    in_action,
  input  logic [pfba_pkg::FRAME_W-1:0]  in_frame_number,
  input  logic [pfba_pkg::LIM_W-1:0]    in_range_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pfba_pkg::FRAME_W-1:0]  out_alloc_frame_number,
  output logic [pfba_pkg::STATUS_W-1:0] out_status,
  output logic                          out_is_free,
  input  logic                          cfg_wr_en,
  input  logic [pfba_pkg::LIM_W-1:0]    cfg_frame_limit
);
  import pfba_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequence each transaction
  pfba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Bitmap, cache and result registers
  pfba_dp #(
    .MAX_FRAMES  (MAX_FRAMES),
    .CACHE_DEPTH (CACHE_DEPTH)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_action              (in_action),
    .in_frame_number        (in_frame_number),
    .in_range_end           (in_range_end),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_frame_limit        (cfg_frame_limit),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_alloc_frame_number (out_alloc_frame_number),
    .out_status             (out_status),
    .out_is_free            (out_is_free),
    .cmd                    (cmd),
    .stat                   (stat)
  );

endmodule
